FILE: rtl/lpa_pkg.sv
// Shared widths, register codes and constant tables for the LoRa airtime block.
// No dependencies; imported by lora_packet_airtime.
package lpa_pkg;

   localparam int BW_W      = 19;
   localparam int SF_W      = 4;
   localparam int PRE_W     = 16;
   localparam int CR_W      = 4;
   localparam int LEN_W     = 8;
   localparam int AIR_W     = 48;
   localparam int NSYM_W    = 13;
   localparam int SYMT_W    = 41;   // 65536000 << 15 stays below 2^41
   localparam int TOTAL_W   = 19;   // 4*P + 17 + 4*N
   localparam int RECIP_W   = 17;   // ceil(2^16 / k), k from 1 to 15
   localparam int RECIP_SH  = 16;
   localparam int XQ_W      = 10;   // ceiling-division operand and quotient
   localparam int CNT_W     = 6;
   localparam int ADDR_W    = 4;
   localparam int CSR_W     = 32;

   localparam logic [25:0] SYM_SCALE = 26'd65536000;   // 1000 * 2^16
   localparam logic [SYMT_W-1:0] LDRO_LIMIT = SYMT_W'(16 * 65536);

   localparam logic [BW_W-1:0]  BW_RESET  = 19'd125000;
   localparam logic [SF_W-1:0]  SF_RESET  = 4'd7;
   localparam logic [PRE_W-1:0] PRE_RESET = 16'd8;
   localparam logic [CR_W-1:0]  CR_RESET  = 4'd5;

   localparam logic [NSYM_W-1:0] HDR_SYMS   = 13'd8;
   localparam logic [TOTAL_W-1:0] FIXED_QSYM = 19'd17;   // 4.25 symbols in quarters
   localparam logic [CR_W-1:0]  CR_MIN     = 4'd5;
   localparam logic [9:0]       LEN_OFFSET = 10'd11;

   typedef enum logic [1:0] {
      REG_BANDWIDTH = 2'd0,
      REG_SPREAD    = 2'd1,
      REG_PREAMBLE  = 2'd2,
      REG_CODING    = 2'd3
   } reg_idx_type;

   // ceil(2^16 / k); exact floor division for operands below 2^16 / 15
   function automatic logic [RECIP_W-1:0] recip_lookup(input logic [SF_W-1:0] k);
      logic [RECIP_W-1:0] r;
      case (k)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13108;
         4'd6:    r = 17'd10923;
         4'd7:    r = 17'd9363;
         4'd8:    r = 17'd8192;
         4'd9:    r = 17'd7282;
         4'd10:   r = 17'd6554;
         4'd11:   r = 17'd5958;
         4'd12:   r = 17'd5462;
         4'd13:   r = 17'd5042;
         4'd14:   r = 17'd4682;
         4'd15:   r = 17'd4370;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/lora_packet_airtime.sv
// LoRa time on air: a pipeline taking one item per cycle unless rsp_tready holds it back.
// Symbol time comes from a bit-serial divider run once per configuration:
// after reset and after every register write, no item is accepted while the load
// step, the 41-step divider and its finishing step complete.
// Reset is synchronous, active high; registers return to 125000 Hz, SF7, 8, 4/5.
// Depends on lpa_pkg.
module lora_packet_airtime (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata: payload_length[7:0]
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,
   // rsp_tdata: airtime_q16_ms[47:0], payload_symbols[60:48], low_rate_opt[61],
   //            result_valid[62], zero[63]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lpa_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [lpa_pkg::CSR_W-1:0]     csr_pwdata,
   output logic [lpa_pkg::CSR_W-1:0]     csr_prdata,
   output logic                          csr_pready
);
   import lpa_pkg::*;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DIV,
      ST_FIN,
      ST_RUN
   } state_type;

   // configuration registers
   logic [BW_W-1:0]  bw_ff;
   logic [SF_W-1:0]  sf_ff;
   logic [PRE_W-1:0] pre_ff;
   logic [CR_W-1:0]  cr_ff;
   logic             csr_wr;
   reg_idx_type      csr_idx;

   // derived settings
   state_type          state_ff;
   logic [SYMT_W-1:0]  quo_ff;
   logic [BW_W-1:0]    rem_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [SYMT_W-1:0]  symt_ff;
   logic               ldro_ff;
   logic [SF_W-1:0]    k_ff;
   logic               kpos_ff;
   logic [RECIP_W-1:0] recip_ff;
   logic [BW_W:0]      trial;
   logic               trial_ge;
   logic [SF_W:0]      k_full;
   logic               ldro_in;

   // pipeline
   logic [6:1]           v_ff;
   logic [7:1]           rdy;
   logic [XQ_W-1:0]      s1_x_ff;
   logic                 s1_pos_ff;
   logic [XQ_W-1:0]      s2_q_ff;
   logic                 s2_pos_ff;
   logic [NSYM_W-1:0]    s3_nsym_ff;
   logic [TOTAL_W-1:0]   s4_total_ff;
   logic [NSYM_W-1:0]    s4_nsym_ff;
   logic [39:0]          s5_plo_ff;
   logic [38:0]          s5_phi_ff;
   logic [NSYM_W-1:0]    s5_nsym_ff;
   logic [AIR_W-1:0]     s6_air_ff;
   logic [NSYM_W-1:0]    s6_nsym_ff;

   logic [9:0]           len_m;
   logic                 s1_pos_in;
   logic [XQ_W:0]        s1_x_wide;
   logic [XQ_W-1:0]      s1_x_in;
   logic [26:0]          s2_prod;
   logic [CR_W-1:0]      cr4;
   logic [13:0]          s3_extra;
   logic [NSYM_W-1:0]    s3_nsym_in;
   logic [TOTAL_W-1:0]   s4_total_in;
   logic [59:0]          s6_full;
   logic [57:0]          s6_quarter;
   logic [AIR_W-1:0]     s6_air_in;
   logic                 cfg_ok;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_idx_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff  <= BW_RESET;
         sf_ff  <= SF_RESET;
         pre_ff <= PRE_RESET;
         cr_ff  <= CR_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_BANDWIDTH: bw_ff  <= csr_pwdata[BW_W-1:0];
            REG_SPREAD:    sf_ff  <= csr_pwdata[SF_W-1:0];
            REG_PREAMBLE:  pre_ff <= csr_pwdata[PRE_W-1:0];
            REG_CODING:    cr_ff  <= csr_pwdata[CR_W-1:0];
            default:       bw_ff  <= bw_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_BANDWIDTH: csr_prdata = CSR_W'(bw_ff);
         REG_SPREAD:    csr_prdata = CSR_W'(sf_ff);
         REG_PREAMBLE:  csr_prdata = CSR_W'(pre_ff);
         REG_CODING:    csr_prdata = CSR_W'(cr_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------- symbol time divider ----------------
   assign trial    = {rem_ff, quo_ff[SYMT_W-1]};
   assign trial_ge = trial >= {1'b0, bw_ff};
   assign ldro_in  = symt_ff >= LDRO_LIMIT;
   assign k_full   = {1'b0, sf_ff} - {3'b000, ldro_in, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else if (csr_wr) begin
         state_ff <= ST_LOAD;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               quo_ff   <= SYMT_W'(SYM_SCALE) << sf_ff;
               rem_ff   <= '0;
               cnt_ff   <= CNT_W'(SYMT_W - 1);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               // restoring step: shift in one numerator bit, subtract when it fits
               if (trial_ge) begin
                  rem_ff <= BW_W'(trial - {1'b0, bw_ff});
               end else begin
                  rem_ff <= trial[BW_W-1:0];
               end
               quo_ff <= {quo_ff[SYMT_W-2:0], trial_ge};
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == '0) begin
                  symt_ff  <= {quo_ff[SYMT_W-2:0], trial_ge};
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               ldro_ff  <= ldro_in;
               kpos_ff  <= !k_full[SF_W] && (k_full[SF_W-1:0] != '0);
               k_ff     <= k_full[SF_W-1:0];
               recip_ff <= recip_lookup(k_full[SF_W-1:0]);
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               state_ff <= ST_RUN;
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   // ---------------- item pipeline ----------------
   always_comb begin
      rdy[7] = rsp_tready;
      for (int i = 6; i >= 1; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign req_tready = (state_ff == ST_RUN) && rdy[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[1]) v_ff[1] <= req_tvalid && req_tready;
         for (int i = 2; i <= 6; i++) begin
            if (rdy[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // stage 1: ceil(M / k) operand, M = 2*len + 11 - SF
   assign len_m     = {1'b0, req_tdata, 1'b0} + LEN_OFFSET;
   assign s1_pos_in = kpos_ff && (len_m > {6'd0, sf_ff});
   assign s1_x_wide = {1'b0, len_m} - {7'd0, sf_ff} + {7'd0, k_ff} - 11'd1;
   assign s1_x_in   = s1_x_wide[XQ_W-1:0];

   // stage 2: divide by k through its reciprocal
   assign s2_prod = s1_x_ff * recip_ff;

   // stage 3: coded symbol count
   assign cr4        = (cr_ff < CR_MIN) ? CR_MIN : cr_ff;
   assign s3_extra   = s2_q_ff * cr4;
   assign s3_nsym_in = s2_pos_ff ? NSYM_W'(HDR_SYMS + s3_extra) : HDR_SYMS;

   // stage 4: quarter symbols in the packet
   assign s4_total_in = {1'b0, pre_ff, 2'b00} + FIXED_QSYM + {4'd0, s3_nsym_ff, 2'b00};

   // stage 6: join partial products, drop quarters, saturate
   assign s6_full    = {s5_phi_ff, 21'd0} + {20'd0, s5_plo_ff};
   assign s6_quarter = s6_full[59:2];
   assign s6_air_in  = (s6_quarter[57:AIR_W] != '0) ? '1 : s6_quarter[AIR_W-1:0];

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_x_ff   <= s1_x_in;
         s1_pos_ff <= s1_pos_in;
      end
      if (rdy[2]) begin
         s2_q_ff   <= s2_prod[RECIP_SH +: XQ_W];
         s2_pos_ff <= s1_pos_ff;
      end
      if (rdy[3]) begin
         s3_nsym_ff <= s3_nsym_in;
      end
      if (rdy[4]) begin
         s4_total_ff <= s4_total_in;
         s4_nsym_ff  <= s3_nsym_ff;
      end
      if (rdy[5]) begin
         s5_plo_ff  <= s4_total_ff * symt_ff[20:0];
         s5_phi_ff  <= s4_total_ff * symt_ff[SYMT_W-1:21];
         s5_nsym_ff <= s4_nsym_ff;
      end
      if (rdy[6]) begin
         s6_air_ff  <= s6_air_in;
         s6_nsym_ff <= s5_nsym_ff;
      end
   end

   // zero bandwidth or spreading factor forces an all-zero result
   assign cfg_ok     = (bw_ff != '0) && (sf_ff != '0);
   assign rsp_tvalid = v_ff[6];
   assign rsp_tdata  = cfg_ok ? {2'b01, ldro_ff, s6_nsym_ff, s6_air_ff} : 64'd0;

endmodule

FILE: verif/lora_airtime_checker.sv
`timescale 1ns / 1ps
// Checker for lora_packet_airtime: follows the register writes, predicts each
// result from the accepted payload length and compares it with the block's output.
// Depends on lpa_pkg.
module lora_airtime_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   // req_tdata: payload_length[7:0]
   input  logic [7:0]                 req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // rsp_tdata: airtime_q16_ms[47:0], payload_symbols[60:48], low_rate_opt[61],
   //            result_valid[62], zero[63]
   input  logic [63:0]                rsp_tdata,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [lpa_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [lpa_pkg::CSR_W-1:0]  csr_pwdata,
   input  logic                       csr_pready,
   output int                         fail_count,
   output int                         pending
);
   import lpa_pkg::*;

   localparam logic [63:0] MS_Q16_SCALE = 64'd65536000;
   localparam logic [63:0] LOW_RATE_SYMT = 64'd1048576;   // 16 ms in Q16
   localparam logic [63:0] AIRTIME_SAT = 64'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic              spare;
      logic              ok;
      logic              low_rate;
      logic [NSYM_W-1:0] symbols;
      logic [AIR_W-1:0]  airtime;
   } airtime_result_type;

   logic [BW_W-1:0]  bw_q;
   logic [SF_W-1:0]  sf_q;
   logic [PRE_W-1:0] pre_q;
   logic [CR_W-1:0]  cr_q;

   airtime_result_type expected_airtimes[$];

   function automatic airtime_result_type predict_airtime(input logic [LEN_W-1:0] len);
      airtime_result_type r;
      logic [63:0]     sym_time;
      logic [63:0]     quarters;
      logic [63:0]     product;
      longint          sf_s;
      longint          divisor;
      longint          numer;
      longint          rate;
      longint          extra;
      r = '0;
      if (bw_q == '0 || sf_q == '0)
         return r;
      sym_time = (64'd1 << sf_q) * MS_Q16_SCALE / 64'(bw_q);
      r.low_rate = (sym_time >= LOW_RATE_SYMT);
      sf_s = longint'(sf_q);
      divisor = 4 * (sf_s - 2 * longint'(r.low_rate));
      if (divisor <= 0) begin
         r.symbols = NSYM_W'(8);
      end else begin
         numer = 8 * longint'(len) - 4 * sf_s + 44;
         rate = longint'(cr_q) - 4;
         if (rate < 1)
            rate = 1;
         // round up for positive numerators, toward zero otherwise
         if (numer >= 0)
            extra = (numer + divisor - 1) / divisor;
         else
            extra = -((-numer) / divisor);
         extra = extra * (rate + 4);
         if (extra < 0)
            extra = 0;
         r.symbols = NSYM_W'(8 + extra);
      end
      quarters = 4 * 64'(pre_q) + 17 + 4 * 64'(r.symbols);
      product = (quarters * sym_time) >> 2;
      r.airtime = (product > AIRTIME_SAT) ? '1 : product[AIR_W-1:0];
      r.ok = 1'b1;
      return r;
   endfunction

   always @(posedge clock) begin
      airtime_result_type want;
      airtime_result_type got;
      if (reset) begin
         bw_q = BW_RESET;
         sf_q = SF_RESET;
         pre_q = PRE_RESET;
         cr_q = CR_RESET;
         expected_airtimes.delete();
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_idx_type'(csr_paddr[3:2]))
               REG_BANDWIDTH: bw_q = csr_pwdata[BW_W-1:0];
               REG_SPREAD:    sf_q = csr_pwdata[SF_W-1:0];
               REG_PREAMBLE:  pre_q = csr_pwdata[PRE_W-1:0];
               REG_CODING:    cr_q = csr_pwdata[CR_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_airtimes.push_back(predict_airtime(req_tdata[LEN_W-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_airtimes.size() == 0) begin
               $display("%0t: unexpected result item, actual %h", $realtime, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_airtimes.pop_front();
               if (got.airtime !== want.airtime)
                  $display("%0t: airtime mismatch, expected %h actual %h",
                           $realtime, want.airtime, got.airtime);
               if (got.symbols !== want.symbols)
                  $display("%0t: symbol count mismatch, expected %0d actual %0d",
                           $realtime, want.symbols, got.symbols);
               if (got.low_rate !== want.low_rate)
                  $display("%0t: low rate flag mismatch, expected %b actual %b",
                           $realtime, want.low_rate, got.low_rate);
               if (got.ok !== want.ok)
                  $display("%0t: valid flag mismatch, expected %b actual %b",
                           $realtime, want.ok, got.ok);
               if (got.spare !== want.spare)
                  $display("%0t: spare bit mismatch, expected %b actual %b",
                           $realtime, want.spare, got.spare);
               if (got !== want)
                  fail_count <= fail_count + 1;
            end
         end
      end
      pending <= expected_airtimes.size();
   end

endmodule

FILE: verif/tb_lora_packet_airtime.sv
`timescale 1ns / 1ps
// Top of the lora_packet_airtime testbench: clock, reset, register setup and
// payload stimulus with random idling; checking lives in lora_airtime_checker.
// Depends on lpa_pkg, lora_packet_airtime and lora_airtime_checker.
module tb_lora_packet_airtime;
   import lpa_pkg::*;

   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS = 50;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   // req_tdata: payload_length[7:0]
   logic [7:0]        req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   // rsp_tdata: airtime_q16_ms[47:0], payload_symbols[60:48], low_rate_opt[61],
   //            result_valid[62], zero[63]
   logic [63:0]       rsp_tdata;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [CSR_W-1:0]  csr_pwdata;
   logic [CSR_W-1:0]  csr_prdata;
   logic              csr_pready;
   int                fail_count;
   int                pending;

   bit sender_gaps;
   bit receiver_gaps;
   bit long_hold_req;

   always #1 clock = ~clock;

   lora_packet_airtime i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lora_airtime_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   task automatic send_length(input logic [LEN_W-1:0] len);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= len;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // drop valid and wait until every outstanding result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_idx_type idx, input logic [CSR_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_W'(idx) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic apply_settings(input int bw, input int sf, input int pre, input int cr);
      drain_results();
      csr_write(REG_BANDWIDTH, CSR_W'(bw));
      csr_write(REG_SPREAD, CSR_W'(sf));
      csr_write(REG_PREAMBLE, CSR_W'(pre));
      csr_write(REG_CODING, CSR_W'(cr));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic int pick_bandwidth();
      case ($urandom_range(0, 15))
         0:       return 0;
         1, 2:    return $urandom_range(1, 2000);
         3:       return 524287;
         default: return $urandom_range(7800, 500000);
      endcase
   endfunction

   function automatic int pick_spread();
      case ($urandom_range(0, 4))
         0:       return $urandom_range(0, 15);
         default: return $urandom_range(5, 12);
      endcase
   endfunction

   function automatic int pick_preamble();
      case ($urandom_range(0, 4))
         0:       return $urandom_range(0, 65535);
         default: return $urandom_range(4, 64);
      endcase
   endfunction

   // receiver: random stalls, plus one long hold on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
      long_hold_req = 1'b0;
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings, length extremes and alternating bits
      send_length(8'd0);
      send_length(8'd255);
      send_length(8'h55);
      send_length(8'hAA);
      // zero bandwidth, then zero spreading factor
      apply_settings(0, 7, 8, 5);
      send_length(8'd255);
      apply_settings(125000, 0, 8, 5);
      send_length(8'd17);
      // saturated airtime at the slowest settings
      apply_settings(1, 15, 65535, 15);
      send_length(8'd0);
      send_length(8'd255);
      // zero and negative divisor with low data rate at tiny spreading factors
      apply_settings(100, 2, 0, 0);
      send_length(8'd0);
      send_length(8'd255);
      apply_settings(1, 1, 3, 4);
      send_length(8'd200);
      // widest bandwidth, negative numerator at SF12 with short payload
      apply_settings(524287, 12, 0, 8);
      send_length(8'd0);
      send_length(8'd255);
      apply_settings(500000, 5, 65535, 9);
      send_length(8'd1);
      send_length(8'd254);
      apply_settings(125000, 12, 8, 7);
      send_length(8'd10);
      send_length(8'd51);
      apply_settings(62500, 13, 12, 6);
      send_length(8'd128);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         apply_settings(pick_bandwidth(), pick_spread(), pick_preamble(),
                        $urandom_range(0, 15));
         if (p == RANDOM_PHASES - 1) begin
            sender_gaps = 1'b0;
            receiver_gaps = 1'b0;
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 2 && k == 5)
               long_hold_req = 1'b1;
            send_length(LEN_W'($urandom_range(0, 255)));
         end
      end

      drain_results();
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #400000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: lora_packet_airtime.f
rtl/lpa_pkg.sv
rtl/lora_packet_airtime.sv
verif/lora_airtime_checker.sv
verif/tb_lora_packet_airtime.sv
